@@ rtl/core/mcfp_pkg.sv @@
// Package with the shared types and constants of the mouse command frame parser.
`timescale 1ns / 1ps
`default_nettype none

package mcfp_pkg;

   // Number of bytes in one frame, and the number held between transactions.
   localparam int unsigned FRAME_LEN = 5;
   localparam int unsigned HELD_MAX  = FRAME_LEN - 1;

   // Range of valid frame type bytes.
   localparam logic [7:0] TYPE_FIRST = 8'hC1;
   localparam logic [7:0] TYPE_LAST  = 8'hC5;

   // Event kinds, numbered as the type byte minus the first type.
   typedef enum logic [2:0] {
      EVT_PRESS       = 3'd0,
      EVT_RELEASE     = 3'd1,
      EVT_MOVE        = 3'd2,
      EVT_RELEASE_ALL = 3'd3,
      EVT_SCROLL      = 3'd4
   } event_kind_type;

   // One decoded event, with a flag that says a frame was recognised.
   typedef struct packed {
      logic              hit;
      event_kind_type    kind;
      logic [7:0]        button;
      logic signed [7:0] move_x;
      logic signed [7:0] move_y;
      logic signed [7:0] wheel;
   } frame_event_type;

endpackage

`default_nettype wire

@@ rtl/core/mouse_command_frame_parser.sv @@
// Top level of the mouse command frame parser.
//
//   Channel | Direction | Payload
//   req_    | in        | rx_byte
//   rsp_    | out       | event_kind, button_code, move_x, move_y, wheel
//
// One byte is taken per cycle unless stalled; a frame result enters the
// single result register in the cycle after its checksum byte is taken.
// The input is stalled only while that register holds a result not yet taken.
// Reset is synchronous and empties the window and forgets the last frame id.
// Most bytes give no result; the rate is set by the input and output handshakes.
`timescale 1ns / 1ps
`default_nettype none

module mouse_command_frame_parser (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [7:0]         req_rx_byte,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [2:0]              rsp_event_kind,
   output logic [7:0]              rsp_button_code,
   output logic signed [7:0]       rsp_move_x,
   output logic signed [7:0]       rsp_move_y,
   output logic signed [7:0]       rsp_wheel
);

   logic                      take;
   mcfp_pkg::frame_event_type evt;
   mcfp_pkg::frame_event_type rsp_data;

   // Accept a byte whenever the result register is free or being emptied.
   assign req_ready = !rsp_valid || rsp_ready;
   assign take      = req_valid && req_ready;

   mcfp_window u_window (
      .clock   (clock),
      .reset   (reset),
      .take    (take),
      .rx_byte (req_rx_byte),
      .evt     (evt)
   );

   mcfp_out_reg u_out_reg (
      .clock (clock),
      .reset (reset),
      .evt   (evt),
      .valid (rsp_valid),
      .ready (rsp_ready),
      .data  (rsp_data)
   );

   // Result fields.
   assign rsp_event_kind  = rsp_data.kind;
   assign rsp_button_code = rsp_data.button;
   assign rsp_move_x      = rsp_data.move_x;
   assign rsp_move_y      = rsp_data.move_y;
   assign rsp_wheel       = rsp_data.wheel;

`ifndef SYNTH
   // An event is only decoded from an accepted byte.
   a_hit_needs_take: assert property (@(posedge clock) disable iff (reset)
      evt.hit |-> take)
      else $error("event decoded without an input transaction");

   // A new result appears only after an input transaction.
   a_valid_from_take: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(take))
      else $error("result raised without an input transaction");

   // Movement fields are zero except in a move event.
   a_move_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_event_kind != mcfp_pkg::EVT_MOVE)) |->
         ((rsp_move_x == 8'sd0) && (rsp_move_y == 8'sd0)))
      else $error("movement field set outside a move event");
`endif

endmodule

`default_nettype wire

@@ rtl/core/mcfp_window.sv @@
// Byte window, frame check and event decode of the mouse command frame parser.
`timescale 1ns / 1ps
`default_nettype none

module mcfp_window (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      take,
   input  wire logic [7:0]                rx_byte,
   output mcfp_pkg::frame_event_type      evt
);

   localparam int unsigned DEPTH = mcfp_pkg::HELD_MAX;

   logic [7:0] window_ff [DEPTH];
   logic [7:0] window_in [DEPTH];
   logic [2:0] count_ff;
   logic [2:0] count_in;
   logic [7:0] last_id_ff;
   logic [7:0] last_id_in;
   logic       last_id_valid_ff;
   logic       last_id_valid_in;

   logic       full;
   logic [7:0] sum;
   logic       repeat_id;
   logic       sum_ok;
   logic       type_ok;
   logic       pass;
   logic [7:0] kind_raw;

   // Frame check on the four held bytes plus the arriving checksum byte.
   always_comb begin
      full      = (count_ff == 3'(DEPTH));
      sum       = window_ff[0] + window_ff[1] + window_ff[2] + window_ff[3];
      repeat_id = last_id_valid_ff && (window_ff[1] == last_id_ff);
      sum_ok    = (sum == rx_byte);
      type_ok   = (window_ff[0] >= mcfp_pkg::TYPE_FIRST) &&
                  (window_ff[0] <= mcfp_pkg::TYPE_LAST);
      pass      = full && !repeat_id && sum_ok && type_ok;
      kind_raw  = window_ff[0] - mcfp_pkg::TYPE_FIRST;
   end

   // Event decode; fields that the event does not use are zero.
   always_comb begin
      evt        = '0;
      evt.hit    = take && pass;
      evt.kind   = mcfp_pkg::event_kind_type'(kind_raw[2:0]);
      case (evt.kind)
         mcfp_pkg::EVT_PRESS, mcfp_pkg::EVT_RELEASE: begin
            evt.button = window_ff[2];
         end
         mcfp_pkg::EVT_MOVE: begin
            evt.move_x = window_ff[2];
            evt.move_y = window_ff[3];
         end
         mcfp_pkg::EVT_SCROLL: begin
            evt.wheel = window_ff[2];
         end
         default: begin
            evt.button = '0;
         end
      endcase
   end

   // Next window state: fill, slide by one on a failed check, or empty on a frame.
   always_comb begin
      window_in        = window_ff;
      count_in         = count_ff;
      last_id_in       = last_id_ff;
      last_id_valid_in = last_id_valid_ff;
      if (take) begin
         if (!full) begin
            for (int i = 0; i < DEPTH; i++) begin
               if (count_ff[1:0] == 2'(i)) begin
                  window_in[i] = rx_byte;
               end
            end
            count_in = count_ff + 3'd1;
         end else if (pass) begin
            count_in         = '0;
            last_id_in       = window_ff[1];
            last_id_valid_in = 1'b1;
         end else begin
            for (int i = 0; i < DEPTH - 1; i++) begin
               window_in[i] = window_ff[i + 1];
            end
            window_in[DEPTH - 1] = rx_byte;
         end
      end
   end

   // Control state with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff         <= '0;
         last_id_ff       <= '0;
         last_id_valid_ff <= 1'b0;
      end else begin
         count_ff         <= count_in;
         last_id_ff       <= last_id_in;
         last_id_valid_ff <= last_id_valid_in;
      end
   end

   // Window bytes need no reset.
   always_ff @(posedge clock) begin
      window_ff <= window_in;
   end

endmodule

`default_nettype wire

@@ rtl/core/mcfp_out_reg.sv @@
// Result register of the mouse command frame parser.
`timescale 1ns / 1ps
`default_nettype none

module mcfp_out_reg (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire mcfp_pkg::frame_event_type evt,
   output logic                           valid,
   input  wire logic                      ready,
   output mcfp_pkg::frame_event_type      data
);

   logic                      valid_ff;
   logic                      valid_in;
   mcfp_pkg::frame_event_type data_ff;

   // Valid is set by a new event and cleared once the transaction completes.
   always_comb begin
      valid_in = valid_ff && !ready;
      if (evt.hit) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload is loaded only when a new event arrives.
   always_ff @(posedge clock) begin
      if (evt.hit) begin
         data_ff <= evt;
      end
   end

   assign valid = valid_ff;
   assign data  = data_ff;

endmodule

`default_nettype wire
